// ===== src/tmw_pkg.sv =====
// ----------------------------------------------------------------------------
// tmw_pkg
// shared constants, types and helpers for the text mode terminal writer
// ----------------------------------------------------------------------------
package tmw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int HTAB_STOP  = 4;
  localparam int VTAB_STOP  = 4;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CMD_W   = 2;
  localparam int CELL_W  = 16;
  localparam int CELL_AW = $clog2(CELL_COUNT);

  localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ATTR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_HT  = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0]        BLANK_CHAR = 8'h20;
  localparam logic [7:0]        RESET_ATTR = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, BLANK_CHAR};

  typedef struct packed {
    logic              wr;
    logic [CELL_W-1:0] wdata;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              scroll;
    logic              clear;
  } tmw_act_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    cell_addr = CELL_AW'(row) * CELL_AW'(COLUMNS) + CELL_AW'(col);
  endfunction

endpackage

// ===== src/text_mode_terminal_writer.sv =====
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// 80x25 character-cell terminal engine over a single-port-write cell ram
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows
// for exactly one cycle with done_o and cannot be held off. A put character
// that neither scrolls nor clears, set attribute, an out-of-range read and
// the unused command give their result in the cycle after the item and
// leave busy low, so one item per cycle. An in-range read waits in ST_RDWAIT
// for the registered ram read, then registers the cell with done_o. A scroll
// copies each cell up one row with a read state and a write state, then
// blanks the bottom row. A form feed sweeps all 2000 cells, one per cycle.
// After reset the same clearing pass runs with busy high before any item.
module text_mode_terminal_writer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [tmw_pkg::CMD_W-1:0]   cmd_i,
  input  logic [7:0]                  data_byte_i,
  input  logic [tmw_pkg::COL_W-1:0]   read_col_i,
  input  logic [tmw_pkg::ROW_W-1:0]   read_row_i,
  output logic                        done_o,
  output logic [tmw_pkg::CELL_W-1:0]  cell_value_o,
  output logic [tmw_pkg::COL_W-1:0]   cursor_col_o,
  output logic [tmw_pkg::ROW_W-1:0]   cursor_row_o,
  output logic [7:0]                  attribute_now_o
);

  import tmw_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDWAIT = 3'd1;
  localparam logic [2:0] ST_SCR_RD = 3'd2;
  localparam logic [2:0] ST_SCR_WR = 3'd3;
  localparam logic [2:0] ST_BLANK  = 3'd4;
  localparam logic [2:0] ST_CLR    = 3'd5;
  localparam logic [2:0] ST_INIT   = 3'd6;

  localparam logic [CELL_AW-1:0] SCROLL_LAST = CELL_AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [CELL_AW-1:0] CELL_LAST   = CELL_AW'(CELL_COUNT - 1);

  logic [2:0]         state_q, state_d;
  logic [CELL_AW-1:0] addr_q, addr_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [7:0]         attr_q, attr_d;
  logic               done_q, done_d;
  logic [CELL_W-1:0]  cell_q, cell_d;

  logic               accept;
  logic               rd_in_range;
  tmw_act_t           act;

  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [CELL_AW-1:0] mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign rd_in_range = (read_col_i < COL_W'(COLUMNS)) && (read_row_i < ROW_W'(ROWS));

  tmw_cursor u_cursor (
    .data_i (data_byte_i),
    .col_i  (col_q),
    .row_i  (row_q),
    .attr_i (attr_q),
    .act_o  (act)
  );

  tmw_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // ram port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = RESET_CELL;
    mem_re    = 1'b0;
    mem_raddr = addr_q + CELL_AW'(COLUMNS);
    case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i == CMD_PUT && act.wr) begin
          mem_we    = 1'b1;
          mem_waddr = cell_addr(row_q, col_q);
          mem_wdata = act.wdata;
        end
        if (accept && cmd_i == CMD_READ && rd_in_range) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(read_row_i, read_col_i);
        end
      end
      ST_SCR_RD: begin
        mem_re = 1'b1;
      end
      ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_q, BLANK_CHAR};
      end
      ST_CLR, ST_INIT: begin
        mem_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    col_d   = col_q;
    row_d   = row_q;
    attr_d  = attr_q;
    done_d  = 1'b0;
    cell_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_d = '0;
          case (cmd_i)
            CMD_PUT: begin
              col_d = act.col;
              row_d = act.row;
              if (act.clear) begin
                attr_d  = RESET_ATTR;
                state_d = ST_CLR;
              end else if (act.scroll) begin
                state_d = ST_SCR_RD;
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_ATTR: begin
              attr_d = data_byte_i;
              done_d = 1'b1;
            end
            CMD_READ: begin
              if (rd_in_range) begin
                state_d = ST_RDWAIT;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        cell_d  = mem_rdata;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCR_RD: begin
        state_d = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        addr_d  = addr_q + 1'b1;
        state_d = (addr_q == SCROLL_LAST) ? ST_BLANK : ST_SCR_RD;
      end
      ST_BLANK, ST_CLR: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == CELL_LAST) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_INIT: begin
        addr_d = addr_q + 1'b1;
        if (addr_q == CELL_LAST) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      addr_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      attr_q  <= RESET_ATTR;
      done_q  <= 1'b0;
      cell_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      col_q   <= col_d;
      row_q   <= row_d;
      attr_q  <= attr_d;
      done_q  <= done_d;
      cell_q  <= cell_d;
    end
  end

  assign done_o          = done_q;
  assign cell_value_o    = cell_q;
  assign cursor_col_o    = col_q;
  assign cursor_row_o    = row_q;
  assign attribute_now_o = attr_q;

  // checks
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q < COL_W'(COLUMNS)) && (row_q < ROW_W'(ROWS)))
    else $error("cursor out of screen");

  a_cell_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cell_value_o != '0) |-> $past(state_q == ST_RDWAIT))
    else $error("cell value shown without a read");

  a_clear_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> (attr_q == RESET_ATTR))
    else $error("clear sweep with wrong attribute");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (mem_waddr <= CELL_LAST))
    else $error("cell write beyond screen");

endmodule

// ===== src/tmw_ram.sv =====
// ----------------------------------------------------------------------------
// tmw_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module tmw_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/tmw_cursor.sv =====
// ----------------------------------------------------------------------------
// tmw_cursor
// decodes one put character against the cursor: cell write, next cursor,
// scroll and clear requests
// ----------------------------------------------------------------------------
module tmw_cursor (
  input  logic [7:0]                 data_i,
  input  logic [tmw_pkg::COL_W-1:0] col_i,
  input  logic [tmw_pkg::ROW_W-1:0] row_i,
  input  logic [7:0]                 attr_i,
  output tmw_pkg::tmw_act_t         act_o
);

  import tmw_pkg::*;

  logic [COL_W-1:0] htab;
  logic [ROW_W-1:0] vtab;
  logic             adv;

  assign htab = col_i + COL_W'(HTAB_STOP) - (col_i % COL_W'(HTAB_STOP));
  assign vtab = row_i + ROW_W'(VTAB_STOP) - (row_i % ROW_W'(VTAB_STOP));

  always_comb begin
    act_o       = '0;
    act_o.col   = col_i;
    act_o.row   = row_i;
    act_o.wdata = {attr_i, data_i};
    adv         = 1'b0;
    case (data_i)
      CH_NL: begin
        act_o.wr    = 1'b1;
        act_o.wdata = {attr_i, BLANK_CHAR};
        adv         = 1'b1;
      end
      CH_HT: begin
        if (htab >= COL_W'(COLUMNS)) begin
          adv = 1'b1;
        end else begin
          act_o.col = htab;
        end
      end
      CH_CR: begin
        act_o.col = '0;
      end
      CH_FF: begin
        act_o.clear = 1'b1;
        act_o.col   = '0;
        act_o.row   = '0;
      end
      CH_BS: begin
        if (col_i != '0) begin
          act_o.col = col_i - 1'b1;
        end
      end
      CH_VT: begin
        if (vtab > ROW_W'(ROWS - 1)) begin
          act_o.row = ROW_W'(ROWS - 1);
        end else begin
          act_o.row = vtab;
        end
      end
      CH_BEL: begin
      end
      default: begin
        act_o.wr = 1'b1;
        if (col_i == COL_W'(COLUMNS - 1)) begin
          adv = 1'b1;
        end else begin
          act_o.col = col_i + 1'b1;
        end
      end
    endcase
    if (adv) begin
      act_o.col = '0;
      if (row_i < ROW_W'(ROWS - 1)) begin
        act_o.row = row_i + 1'b1;
      end else begin
        act_o.scroll = 1'b1;
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// testbench for the text mode terminal writer: a shadow copy of the screen,
// cursor and attribute predicts the one result of every accepted item, and
// each strobed result is compared field by field with the oldest prediction.
// a short directed pass covers the corners and every control code, then
// bursts of random items run with random gaps between them.
// ----------------------------------------------------------------------------
module tb;
  import tmw_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 20000;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned DRAIN_CYCLES = 8;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [7:0]        attr;
  } term_report_t;

  class terminal_shadow;
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [7:0]        cur_attr;
    term_report_t      due_reports [$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
      clear_screen();
    endfunction

    function void clear_screen();
      cur_attr = RESET_ATTR;
      cur_col  = 0;
      cur_row  = 0;
      foreach (shadow_cells[i]) shadow_cells[i] = RESET_CELL;
    endfunction

    function void next_line();
      cur_col = 0;
      if (cur_row < ROWS - 1) begin
        cur_row++;
      end else begin
        for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = 0; i < COLUMNS; i++) shadow_cells[(ROWS - 1) * COLUMNS + i] = {cur_attr, BLANK_CHAR};
      end
    endfunction

    function int unsigned outstanding();
      return due_reports.size();
    endfunction

    function void apply_item(logic [CMD_W-1:0] cmd, logic [7:0] data,
                             logic [COL_W-1:0] rcol, logic [ROW_W-1:0] rrow);
      logic [CELL_W-1:0] cell_val;
      term_report_t      rep;
      cell_val = '0;
      case (cmd)
        CMD_PUT: begin
          case (data)
            CH_NL: begin
              shadow_cells[cur_row * COLUMNS + cur_col] = {cur_attr, BLANK_CHAR};
              next_line();
            end
            CH_HT: begin
              cur_col += HTAB_STOP - (cur_col % HTAB_STOP);
              if (cur_col >= COLUMNS) next_line();
            end
            CH_CR: cur_col = 0;
            CH_FF: clear_screen();
            CH_BS: begin
              if (cur_col != 0) cur_col--;
            end
            CH_VT: begin
              cur_row += VTAB_STOP - (cur_row % VTAB_STOP);
              if (cur_row > ROWS - 1) cur_row = ROWS - 1;
            end
            CH_BEL: ;
            default: begin
              shadow_cells[cur_row * COLUMNS + cur_col] = {cur_attr, data};
              cur_col++;
              if (cur_col >= COLUMNS) next_line();
            end
          endcase
        end
        CMD_ATTR: cur_attr = data;
        CMD_READ: begin
          if (rcol < COLUMNS && rrow < ROWS) cell_val = shadow_cells[rrow * COLUMNS + rcol];
        end
        default: ;
      endcase
      rep.cell_val = cell_val;
      rep.col      = COL_W'(cur_col);
      rep.row      = ROW_W'(cur_row);
      rep.attr     = cur_attr;
      due_reports.push_back(rep);
    endfunction

    function void compare_field(string name, logic [CELL_W-1:0] want, logic [CELL_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void retire_report(logic [CELL_W-1:0] cell_val, logic [COL_W-1:0] col,
                                logic [ROW_W-1:0] row, logic [7:0] attr);
      term_report_t want;
      if (due_reports.size() == 0) begin
        $error("result with no item waiting: cell_value %0h", cell_val);
        mismatches++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("cell_value", want.cell_val, cell_val);
      compare_field("cursor_col", CELL_W'(want.col), CELL_W'(col));
      compare_field("cursor_row", CELL_W'(want.row), CELL_W'(row));
      compare_field("attribute_now", CELL_W'(want.attr), CELL_W'(attr));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [7:0]        data_byte_i = '0;
  logic [COL_W-1:0]  read_col_i = '0;
  logic [ROW_W-1:0]  read_row_i = '0;
  logic              busy;
  logic              done_o;
  logic [CELL_W-1:0] cell_value_o;
  logic [COL_W-1:0]  cursor_col_o;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [7:0]        attribute_now_o;

  terminal_shadow shadow;
  int unsigned    quiet_cycles = 0;

  text_mode_terminal_writer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cmd_i           (cmd_i),
    .data_byte_i     (data_byte_i),
    .read_col_i      (read_col_i),
    .read_row_i      (read_row_i),
    .done_o          (done_o),
    .cell_value_o    (cell_value_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .attribute_now_o (attribute_now_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        shadow.retire_report(cell_value_o, cursor_col_o, cursor_row_o, attribute_now_o);
      end
      if (start && busy === 1'b0) begin
        shadow.apply_item(cmd_i, data_byte_i, read_col_i, read_row_i);
      end
      if (done_o === 1'b1 || (start && busy === 1'b0)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] c, logic [7:0] d,
                           logic [COL_W-1:0] rc, logic [ROW_W-1:0] rr);
    start       <= 1'b1;
    cmd_i       <= c;
    data_byte_i <= d;
    read_col_i  <= rc;
    read_row_i  <= rr;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic pause_sender(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (shadow.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [CMD_W-1:0] c;
    logic [7:0]       d;
    logic [COL_W-1:0] rc;
    logic [ROW_W-1:0] rr;
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      pick;

    shadow = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, out of range reads and the unused command
    send_item(CMD_READ, 8'h00, '0, '0);
    send_item(CMD_READ, 8'hFF, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    send_item(CMD_READ, 8'h00, COL_W'(COLUMNS), '0);
    send_item(CMD_READ, 8'h00, '0, ROW_W'(ROWS));
    send_item(CMD_READ, 8'hFF, 7'h7F, 5'h1F);
    send_item(CMD_NONE, 8'hFF, 7'h7F, 5'h1F);
    // backspace at column 0, extreme bytes, tab, bell, carriage return, newline
    send_item(CMD_PUT, CH_BS, '0, '0);
    send_item(CMD_ATTR, 8'hFF, '0, '0);
    send_item(CMD_PUT, 8'h00, '0, '0);
    send_item(CMD_PUT, 8'hFF, '0, '0);
    send_item(CMD_PUT, 8'h80, '0, '0);
    send_item(CMD_PUT, CH_BS, '0, '0);
    send_item(CMD_PUT, CH_HT, '0, '0);
    send_item(CMD_PUT, CH_BEL, '0, '0);
    send_item(CMD_PUT, CH_CR, '0, '0);
    send_item(CMD_PUT, CH_NL, '0, '0);
    send_item(CMD_READ, 8'h00, '0, '0);
    // vertical tab clamps at the last row
    repeat (7) send_item(CMD_PUT, CH_VT, '0, '0);
    // newline on the last row scrolls with the current attribute
    send_item(CMD_ATTR, 8'h00, '0, '0);
    send_item(CMD_PUT, CH_NL, '0, '0);
    send_item(CMD_READ, 8'h00, '0, ROW_W'(ROWS - 1));
    send_item(CMD_PUT, CH_FF, '0, '0);
    send_item(CMD_READ, 8'h00, COL_W'(COLUMNS - 1), ROW_W'(ROWS - 1));
    wait_drained();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        c  = CMD_PUT;
        d  = 8'($urandom_range(32, 126));
        rc = COL_W'($urandom_range(0, COLUMNS - 1));
        rr = ROW_W'($urandom_range(0, ROWS - 1));
        if (pick < 10) begin
          d = 8'($urandom_range(0, 255));
        end else if (pick < 50) begin
        end else if (pick < 56) begin
          d = CH_NL;
        end else if (pick < 58) begin
          d = CH_VT;
        end else if (pick < 64) begin
          case ($urandom_range(0, 3))
            0: d = CH_BEL;
            1: d = CH_BS;
            2: d = CH_HT;
            default: d = CH_CR;
          endcase
        end else if (pick < 68) begin
          d = CH_HT;
        end else if (pick < 72) begin
          c = CMD_ATTR;
          d = 8'($urandom_range(0, 255));
        end else if (pick < 82) begin
          // cells around the cursor
          c  = CMD_READ;
          d  = 8'($urandom_range(0, 255));
          rr = ROW_W'(shadow.cur_row);
          rc = COL_W'((shadow.cur_col + COLUMNS - 1 + $urandom_range(0, 2)) % COLUMNS);
        end else if (pick < 90) begin
          c = CMD_READ;
          d = 8'($urandom_range(0, 255));
        end else if (pick < 95) begin
          c  = CMD_READ;
          d  = 8'($urandom_range(0, 255));
          rc = COL_W'($urandom_range(0, 127));
          rr = ROW_W'($urandom_range(0, 31));
        end else if (pick < 98) begin
          c  = CMD_NONE;
          d  = 8'($urandom_range(0, 255));
          rc = COL_W'($urandom_range(0, 127));
          rr = ROW_W'($urandom_range(0, 31));
        end else if ($urandom_range(0, 3) == 0) begin
          d = CH_FF;
        end
        send_item(c, d, rc, rr);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_drained();
      end else if ($urandom_range(0, 9) < 7) begin
        pause_sender($urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
